[rtl/core/assert_macros.svh]
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, gated off during reset.
`define ASSERT_IMP(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("implication failed");

// Next-cycle implication, gated off during reset.
`define ASSERT_NXT(name, clk, rstn, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

[rtl/core/tse_pkg.sv]
`default_nettype none
package tse_pkg;

  localparam int STORE_DEPTH_DEF = 4096;
  localparam int MAX_DIMS_DEF    = 4;
  localparam int DATA_WIDTH_DEF  = 32;

  localparam int EXT_W   = 12;
  localparam int EXTS_W  = 48;
  localparam int POS_W   = 12;
  localparam int WORD_W  = 32;
  localparam int DIM_W   = 3;
  localparam int CNT_W   = 4;
  localparam int OFF_W   = 64;
  localparam int CFG_IDX_W = 2;

  // Every packed extent resets to one
  localparam logic [EXTS_W-1:0] EXT_RESET = 48'h001_001_001_001;

  typedef enum logic [1:0] {
    OP_LOAD    = 2'd0,
    OP_SCATTER = 2'd1,
    OP_READ    = 2'd2,
    OP_NONE    = 2'd3
  } tse_op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_REDUCE = 2'd0,
    REG_AXIS   = 2'd1,
    REG_IEXT   = 2'd2,
    REG_OEXT   = 2'd3
  } tse_reg_e;

  typedef struct packed {
    logic              reduce_mode;
    logic [1:0]        scatter_axis;
    logic [EXTS_W-1:0] index_extents;
    logic [EXTS_W-1:0] output_extents;
  } tse_cfg_t;

  typedef struct packed {
    tse_op_e            kind;
    logic [POS_W-1:0]   addr;
    logic [POS_W-1:0]   pos;
    logic [EXT_W-1:0]   axis_coord;
    logic [WORD_W-1:0]  data;
    logic               skip;
  } tse_item_t;

  // Extent of one dimension, outermost first; dimensions past the packed fields are 1.
  function automatic logic [EXT_W-1:0] ext_of(logic [EXTS_W-1:0] r, int unsigned dim,
                                              int unsigned max_dims);
    int shift;
    logic [EXTS_W-1:0] sh;
    shift = EXT_W * (int'(max_dims) - 1 - int'(dim));
    if (shift >= EXTS_W || shift < 0) return EXT_W'(1);
    sh = r >> shift;
    return sh[EXT_W-1:0];
  endfunction

  // Clamp the configured axis to the last dimension.
  function automatic logic [DIM_W-1:0] sat_axis(logic [1:0] a, int unsigned max_dims);
    if (int'(a) > int'(max_dims) - 1) return DIM_W'(max_dims - 1);
    return DIM_W'(a);
  endfunction

endpackage
`default_nettype wire

[rtl/core/tensor_scatter_elements_top.sv]
`default_nettype none
// Channel   Signals                                         Direction
// in        in_valid_i/in_ready_o, op, address, position,   request in
//           index value, data value
// out       out_valid_o/out_ready_i, read data, range flag  result out
// cfg       cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i register write
//
// Load, unused op and skipped scatter go straight to FIN; a read uses RDWAIT.
// A scatter runs a restoring divider, one quotient bit per cycle, for each
// dimension but the outermost, each followed by one multiply-accumulate and
// one stride multiply, then a last multiply-accumulate and a range check. Add
// mode reads the store in RDWAIT first. A two-entry queue takes requests while
// the back end works; reset clears control only, the store is not cleared.
module tensor_scatter_elements_top #(
  parameter int STORE_DEPTH = tse_pkg::STORE_DEPTH_DEF,
  parameter int MAX_DIMS    = tse_pkg::MAX_DIMS_DEF,
  parameter int DATA_WIDTH  = tse_pkg::DATA_WIDTH_DEF
) (
  input  wire                             clk_i,
  input  wire                             rst_ni,
  input  wire                             in_valid_i,
  output logic                            in_ready_o,
  input  wire  [1:0]                      op_i,
  input  wire  [tse_pkg::POS_W-1:0]       element_address_i,
  input  wire  [tse_pkg::POS_W-1:0]       update_position_i,
  input  wire  signed [31:0]              index_value_i,
  input  wire  signed [31:0]              data_value_i,
  output logic                            out_valid_o,
  input  wire                             out_ready_i,
  output logic signed [31:0]              read_data_o,
  output logic                            index_out_of_range_o,
  input  wire                             cfg_valid_i,
  output logic                            cfg_ready_o,
  input  wire  [tse_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire  [tse_pkg::EXTS_W-1:0]      cfg_data_i
);
  import tse_pkg::*;

  tse_cfg_t  cfg_q;
  logic      q_valid, q_ready;
  tse_item_t q_item;

  assign cfg_ready_o = 1'b1;

  // Register file for the configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.reduce_mode    <= 1'b0;
      cfg_q.scatter_axis   <= 2'd3;
      cfg_q.index_extents  <= EXT_RESET;
      cfg_q.output_extents <= EXT_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (tse_reg_e'(cfg_index_i))
        REG_REDUCE: cfg_q.reduce_mode    <= cfg_data_i[0];
        REG_AXIS:   cfg_q.scatter_axis   <= cfg_data_i[1:0];
        REG_IEXT:   cfg_q.index_extents  <= cfg_data_i;
        REG_OEXT:   cfg_q.output_extents <= cfg_data_i;
        default: ;
      endcase
    end
  end

  tse_front #(.MAX_DIMS(MAX_DIMS)) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_i             (cfg_q),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .op_i              (op_i),
    .element_address_i (element_address_i),
    .update_position_i (update_position_i),
    .index_value_i     (index_value_i),
    .data_value_i      (data_value_i),
    .q_valid_o         (q_valid),
    .q_ready_i         (q_ready),
    .q_item_o          (q_item)
  );

  tse_back #(
    .STORE_DEPTH (STORE_DEPTH),
    .MAX_DIMS    (MAX_DIMS),
    .DATA_WIDTH  (DATA_WIDTH)
  ) u_back (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_i                (cfg_q),
    .q_valid_i            (q_valid),
    .q_ready_o            (q_ready),
    .q_item_i             (q_item),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .read_data_o          (read_data_o),
    .index_out_of_range_o (index_out_of_range_o)
  );

endmodule
`default_nettype wire

[rtl/core/tse_front.sv]
`default_nettype none
module tse_front #(
  parameter int MAX_DIMS = tse_pkg::MAX_DIMS_DEF
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  tse_pkg::tse_cfg_t            cfg_i,
  input  wire                          in_valid_i,
  output logic                         in_ready_o,
  input  wire  [1:0]                   op_i,
  input  wire  [tse_pkg::POS_W-1:0]    element_address_i,
  input  wire  [tse_pkg::POS_W-1:0]    update_position_i,
  input  wire  signed [31:0]           index_value_i,
  input  wire  signed [31:0]           data_value_i,
  output logic                         q_valid_o,
  input  wire                          q_ready_i,
  output tse_pkg::tse_item_t           q_item_o
);
  import tse_pkg::*;

  logic [EXT_W-1:0]   size;
  logic signed [32:0] idx_x;
  logic signed [32:0] size_x;
  logic signed [32:0] norm;
  tse_item_t          item;
  tse_item_t          ent_q [2];
  logic               wr_ptr_q, rd_ptr_q;
  logic [1:0]         cnt_q;
  logic               push, pop;

  // Classify the request and range-check the index along the axis
  always_comb begin
    size   = ext_of(cfg_i.output_extents, 32'(sat_axis(cfg_i.scatter_axis, MAX_DIMS)),
                    MAX_DIMS);
    idx_x  = 33'(index_value_i);
    size_x = $signed({21'd0, size});
    norm   = (idx_x < 0) ? idx_x + size_x : idx_x;
    item.kind       = tse_op_e'(op_i);
    item.addr       = element_address_i;
    item.pos        = update_position_i;
    item.axis_coord = norm[EXT_W-1:0];
    item.data       = data_value_i;
    item.skip       = (idx_x >= size_x) || (idx_x < -size_x);
  end

  assign in_ready_o = (cnt_q != 2'd2);
  assign push       = in_valid_i && in_ready_o;
  assign q_valid_o  = (cnt_q != 2'd0);
  assign pop        = q_valid_o && q_ready_i;
  assign q_item_o   = ent_q[rd_ptr_q];

  // Hold classified requests in a two-entry queue
  always_ff @(posedge clk_i) begin
    if (push) ent_q[wr_ptr_q] <= item;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

endmodule
`default_nettype wire

[rtl/core/tse_back.sv]
`default_nettype none
module tse_back #(
  parameter int STORE_DEPTH = tse_pkg::STORE_DEPTH_DEF,
  parameter int MAX_DIMS    = tse_pkg::MAX_DIMS_DEF,
  parameter int DATA_WIDTH  = tse_pkg::DATA_WIDTH_DEF
) (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  tse_pkg::tse_cfg_t         cfg_i,
  input  wire                       q_valid_i,
  output logic                      q_ready_o,
  input  tse_pkg::tse_item_t        q_item_i,
  output logic                      out_valid_o,
  input  wire                       out_ready_i,
  output logic signed [31:0]        read_data_o,
  output logic                      index_out_of_range_o
);
  import tse_pkg::*;

  localparam int AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_DIV    = 3'd1;
  localparam logic [2:0] ST_MACC   = 3'd2;
  localparam logic [2:0] ST_OSCL   = 3'd3;
  localparam logic [2:0] ST_CHECK  = 3'd4;
  localparam logic [2:0] ST_RDWAIT = 3'd5;
  localparam logic [2:0] ST_FIN    = 3'd6;

  logic [2:0]            state_q, state_d;
  tse_item_t             item_q, item_d;
  logic [POS_W-1:0]      dvd_q, dvd_d;
  logic [EXT_W-1:0]      rem_q, rem_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [DIM_W-1:0]      dim_q, dim_d;
  logic [OFF_W-1:0]      off_q, off_d;
  logic [EXTS_W-1:0]     ostr_q, ostr_d;
  logic [31:0]           res_rd_q, res_rd_d;
  logic                  res_flag_q, res_flag_d;
  logic                  out_valid_q;
  logic [31:0]           out_rd_q;
  logic                  out_flag_q;
  logic                  fin_go;

  logic [DATA_WIDTH-1:0] mem [STORE_DEPTH];
  logic [DATA_WIDTH-1:0] mem_rdata_q;
  logic                  mem_we, mem_re;
  logic [AW-1:0]         mem_waddr, mem_raddr;
  logic [DATA_WIDTH-1:0] mem_wdata;

  logic [EXT_W-1:0]      dvsr, iext, oext, coord;
  logic [EXT_W:0]        trial;
  logic                  ge;
  logic [DIM_W-1:0]      axis;
  logic [63:0]           data_x;
  logic signed [63:0]    rd_x;
  logic                  addr_ok;

  // Word store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) mem_rdata_q <= mem[mem_raddr];
  end

  assign q_ready_o = (state_q == ST_IDLE);
  assign fin_go    = (state_q == ST_FIN) && (!out_valid_q || out_ready_i);

  // Do a load or read, or decompose position, accumulate offset, update store
  always_comb begin
    state_d    = state_q;
    item_d     = item_q;
    dvd_d      = dvd_q;
    rem_d      = rem_q;
    cnt_d      = cnt_q;
    dim_d      = dim_q;
    off_d      = off_q;
    ostr_d     = ostr_q;
    res_rd_d   = res_rd_q;
    res_flag_d = res_flag_q;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_waddr  = AW'(item_q.addr);
    mem_raddr  = AW'(item_q.addr);
    mem_wdata  = '0;

    axis    = sat_axis(cfg_i.scatter_axis, MAX_DIMS);
    iext    = ext_of(cfg_i.index_extents, 32'(dim_q), MAX_DIMS);
    oext    = ext_of(cfg_i.output_extents, 32'(dim_q), MAX_DIMS);
    dvsr    = (iext == '0) ? EXT_W'(1) : iext;
    trial   = {rem_q, dvd_q[POS_W-1]};
    ge      = (trial >= {1'b0, dvsr});
    coord   = (dim_q == axis) ? item_q.axis_coord : ((dim_q == '0) ? dvd_q : rem_q);
    data_x  = 64'($signed(item_q.data));
    rd_x    = 64'(signed'(mem_rdata_q));
    addr_ok = (32'(item_q.addr) < 32'(STORE_DEPTH));

    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          item_d     = q_item_i;
          res_rd_d   = '0;
          res_flag_d = 1'b0;
          mem_waddr  = AW'(q_item_i.addr);
          mem_raddr  = AW'(q_item_i.addr);
          state_d    = ST_FIN;
          case (q_item_i.kind)
            OP_LOAD: begin
              mem_we    = (32'(q_item_i.addr) < 32'(STORE_DEPTH));
              mem_wdata = DATA_WIDTH'(64'($signed(q_item_i.data)));
            end
            OP_READ: begin
              if (32'(q_item_i.addr) < 32'(STORE_DEPTH)) begin
                mem_re  = 1'b1;
                state_d = ST_RDWAIT;
              end
            end
            OP_SCATTER: begin
              if (q_item_i.skip) begin
                res_flag_d = 1'b1;
              end else begin
                off_d   = '0;
                ostr_d  = EXTS_W'(1);
                dim_d   = DIM_W'(MAX_DIMS - 1);
                dvd_d   = q_item_i.pos;
                rem_d   = '0;
                cnt_d   = '0;
                state_d = (MAX_DIMS > 1) ? ST_DIV : ST_MACC;
              end
            end
            default: ;
          endcase
        end
      end
      ST_DIV: begin
        // One quotient bit per cycle
        rem_d = ge ? EXT_W'(trial - {1'b0, dvsr}) : trial[EXT_W-1:0];
        dvd_d = {dvd_q[POS_W-2:0], ge};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(POS_W - 1)) state_d = ST_MACC;
      end
      ST_MACC: begin
        off_d   = off_q + OFF_W'(ostr_q * coord);
        state_d = (dim_q == '0) ? ST_CHECK : ST_OSCL;
      end
      ST_OSCL: begin
        ostr_d  = EXTS_W'(ostr_q * oext);
        dim_d   = dim_q - 1'b1;
        rem_d   = '0;
        cnt_d   = '0;
        state_d = (dim_q == DIM_W'(1)) ? ST_MACC : ST_DIV;
      end
      ST_CHECK: begin
        mem_waddr = off_q[AW-1:0];
        mem_raddr = off_q[AW-1:0];
        state_d   = ST_FIN;
        if (off_q < OFF_W'(STORE_DEPTH)) begin
          if (cfg_i.reduce_mode) begin
            mem_re  = 1'b1;
            state_d = ST_RDWAIT;
          end else begin
            mem_we    = 1'b1;
            mem_wdata = DATA_WIDTH'(data_x);
          end
        end
      end
      ST_RDWAIT: begin
        mem_waddr = off_q[AW-1:0];
        state_d   = ST_FIN;
        if (item_q.kind == OP_READ) begin
          res_rd_d = addr_ok ? rd_x[31:0] : '0;
        end else begin
          mem_we    = 1'b1;
          mem_wdata = mem_rdata_q + DATA_WIDTH'(data_x);
        end
      end
      ST_FIN: begin
        if (fin_go) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (fin_go)           out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    dvd_q      <= dvd_d;
    rem_q      <= rem_d;
    cnt_q      <= cnt_d;
    dim_q      <= dim_d;
    off_q      <= off_d;
    ostr_q     <= ostr_d;
    res_rd_q   <= res_rd_d;
    res_flag_q <= res_flag_d;
    if (fin_go) begin
      out_rd_q   <= res_rd_q;
      out_flag_q <= res_flag_q;
    end
  end

  assign out_valid_o          = out_valid_q;
  assign read_data_o          = out_rd_q;
  assign index_out_of_range_o = out_flag_q;

endmodule
`default_nettype wire

[rtl/core/tse_checker.sv]
`default_nettype none
`include "assert_macros.svh"
module tse_checker (
  input wire               clk_i,
  input wire               rst_ni,
  input wire               out_valid_o,
  input wire               out_ready_i,
  input wire signed [31:0] read_data_o,
  input wire               index_out_of_range_o,
  input wire               cfg_ready_o
);

  // A result stays offered until taken
  `ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)
  // A skipped scatter never carries read data
  `ASSERT_IMP(a_flag_no_data, clk_i, rst_ni, out_valid_o && index_out_of_range_o,
              read_data_o == 32'd0)
  // Register writes are never stalled
  `ASSERT_IMP(a_cfg_ready, clk_i, rst_ni, 1'b1, cfg_ready_o)
  // Stalled result keeps its data
  `ASSERT_NXT(a_out_stable, clk_i, rst_ni, out_valid_o && !out_ready_i,
              $stable(read_data_o) && $stable(index_out_of_range_o))

endmodule

bind tensor_scatter_elements_top tse_checker u_tse_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .out_valid_o          (out_valid_o),
  .out_ready_i          (out_ready_i),
  .read_data_o          (read_data_o),
  .index_out_of_range_o (index_out_of_range_o),
  .cfg_ready_o          (cfg_ready_o)
);
`default_nettype wire

[bench/tb.sv]
module tb;
  import tse_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [1:0] op_i = OP_LOAD;
  logic [POS_W-1:0] element_address_i = '0;
  logic [POS_W-1:0] update_position_i = '0;
  logic signed [31:0] index_value_i = '0;
  logic signed [31:0] data_value_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [31:0] read_data_o;
  logic index_out_of_range_o;
  logic cfg_valid_i = 1'b0;
  logic cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i = REG_REDUCE;
  logic [EXTS_W-1:0] cfg_data_i = '0;

  tensor_scatter_elements_top i_dut (.*);

  typedef struct packed {
    logic [31:0] rdata;
    logic        oor;
  } tse_result_t;

  // predictor state
  logic [31:0] model_store [0:4095];
  bit written [0:4095];
  logic        m_reduce;
  logic [1:0]  m_axis;
  logic [47:0] m_iext, m_oext;
  tse_result_t expected_results [$];
  int errors = 0;
  int idle_cycles = 0;
  bit quiet = 0;

  localparam int WATCHDOG = 20000;

  initial forever #1 clk_i = ~clk_i;

  function automatic int ext_at(logic [47:0] r, int d);
    return int'(r[12*(3-d) +: 12]);
  endfunction

  // Work out the store offset of a scatter; returns 1 when the index is out of range.
  function automatic bit scatter_offset(logic [11:0] pos, logic signed [31:0] idx,
                                        output longint off);
    longint ist [4];
    longint ost [4];
    longint remain, coord, sz, iv;
    int ie;
    ist[3] = 1; ost[3] = 1;
    for (int d = 3; d > 0; d--) begin
      ie = ext_at(m_iext, d);
      if (ie == 0) ie = 1;
      ist[d-1] = ist[d] * ie;
      ost[d-1] = ost[d] * ext_at(m_oext, d);
    end
    remain = pos; off = 0; iv = idx;
    for (int d = 0; d < 4; d++) begin
      coord = remain / ist[d];
      remain = remain % ist[d];
      if (d == m_axis) begin
        sz = ext_at(m_oext, d);
        if (iv >= sz || iv < -sz) return 1;
        if (iv < 0) iv += sz;
        coord = iv;
      end
      off += ost[d] * coord;
    end
    return 0;
  endfunction

  function automatic tse_result_t predict_tensor_op(logic [1:0] op, logic [11:0] addr,
      logic [11:0] pos, logic signed [31:0] idx, logic signed [31:0] dval);
    tse_result_t r;
    longint off;
    r = '0;
    case (op)
      OP_LOAD: begin
        model_store[addr] = dval; written[addr] = 1;
      end
      OP_READ: r.rdata = model_store[addr];
      OP_SCATTER: begin
        if (scatter_offset(pos, idx, off)) r.oor = 1'b1;
        else if (off < 4096) begin
          model_store[off] = m_reduce ? model_store[off] + dval : dval;
          written[off] = 1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // hold off for a random burst, unless idling is off
  task automatic maybe_idle();
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
  endtask

  task automatic send_request(logic [1:0] op, logic [11:0] addr, logic [11:0] pos,
                              logic signed [31:0] idx, logic signed [31:0] dval);
    maybe_idle();
    expected_results.push_back(predict_tensor_op(op, addr, pos, idx, dval));
    op_i <= op; element_address_i <= addr; update_position_i <= pos;
    index_value_i <= idx; data_value_i <= dval; in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  task automatic write_reg(tse_reg_e idx, logic [47:0] val);
    cfg_index_i <= idx; cfg_data_i <= val; cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_REDUCE: m_reduce = val[0];
      REG_AXIS:   m_axis = val[1:0];
      REG_IEXT:   m_iext = val;
      default:    m_oext = val;
    endcase
  endtask

  task automatic set_shape(bit reduce, logic [1:0] axis, logic [47:0] iext, logic [47:0] oext);
    drain();
    write_reg(REG_REDUCE, 48'(reduce));
    write_reg(REG_AXIS, 48'(axis));
    write_reg(REG_IEXT, iext);
    write_reg(REG_OEXT, oext);
    cfg_valid_i <= 1'b0;
  endtask

  // fill a region so later reads and adds touch only written words
  task automatic fill_region(int depth);
    for (int a = 0; a < depth; a++)
      send_request(OP_LOAD, 12'(a), 12'($urandom), $urandom, $urandom);
  endtask

  task automatic random_ops(int n, int depth, int pos_max);
    logic [11:0] a;
    logic signed [31:0] idx;
    int sz;
    for (int i = 0; i < n; i++) begin
      a = 12'($urandom_range(0, depth - 1));
      sz = ext_at(m_oext, m_axis);
      case ($urandom_range(0, 9))
        0, 1:    send_request(OP_LOAD, a, 12'($urandom), $urandom, $urandom);
        2, 3:    send_request(written[a] ? OP_READ : OP_LOAD, a, 12'($urandom), $urandom,
                              $urandom);
        4:       send_request(OP_NONE, 12'($urandom), 12'($urandom), $urandom, $urandom);
        5:       send_request(OP_SCATTER, a, 12'($urandom_range(0, pos_max)), $urandom,
                              $urandom);
        default: begin
          idx = $signed($urandom_range(0, 2 * sz + 1)) - sz - 1;
          send_request(OP_SCATTER, a, 12'($urandom_range(0, pos_max)), idx, $urandom);
        end
      endcase
    end
  endtask

  task automatic test_directed();
    set_shape(0, 3, 48'h001_001_001_010, 48'h001_001_001_010);
    fill_region(16);
    send_request(OP_SCATTER, 0, 12'd3, 32'sd15, 32'h7FFF_FFFF);
    send_request(OP_SCATTER, 0, 12'd0, -32'sd16, 32'h8000_0000);
    send_request(OP_SCATTER, 0, 12'd0, 32'sd16, 32'sd1);
    send_request(OP_SCATTER, 0, 12'd0, -32'sd17, 32'sd1);
    send_request(OP_SCATTER, 0, 12'hFFF, 32'sh7FFF_FFFF, 32'sd1);
    send_request(OP_SCATTER, 0, 12'd0, 32'sh8000_0000, 32'sd1);
    send_request(OP_READ, 12'd15, 0, 0, 0);
    send_request(OP_READ, 12'd0, 0, 0, 0);
    send_request(OP_NONE, 12'hFFF, 12'hFFF, -1, -1);
    // add mode wraps
    set_shape(1, 3, 48'h001_001_001_010, 48'h001_001_001_010);
    send_request(OP_SCATTER, 0, 12'd0, 32'sd0, 32'h7FFF_FFFF);
    send_request(OP_SCATTER, 0, 12'd0, 32'sd0, 32'h7FFF_FFFF);
    send_request(OP_READ, 12'd0, 0, 0, 0);
    // zero axis extent flags every scatter; zero index extent acts as one
    set_shape(0, 0, 48'h000_000_000_000, 48'h000_001_001_010);
    send_request(OP_SCATTER, 0, 12'd5, 32'sd0, 32'sd9);
    // offset beyond the store is dropped without a flag
    set_shape(0, 0, 48'hFFF_FFF_FFF_FFF, 48'hFFF_FFF_FFF_FFF);
    send_request(OP_SCATTER, 0, 12'd0, 32'sd4000, 32'sd9);
    send_request(OP_SCATTER, 0, 12'hFFF, 32'sd0, 32'sd9);
    send_request(OP_LOAD, 12'hFFF, 0, 0, 32'sh5555_AAAA);
    send_request(OP_READ, 12'hFFF, 0, 0, 0);
  endtask

  task automatic test_random();
    set_shape(0, 2, 48'h001_002_004_004, 48'h001_002_008_004);
    fill_region(64);
    random_ops(130, 64, 31);
    set_shape(1, 1, 48'h002_002_002_002, 48'h002_004_002_002);
    fill_region(32);
    random_ops(130, 32, 15);
    set_shape(1, 0, 48'h003_002_001_004, 48'h005_002_001_004);
    fill_region(40);
    random_ops(130, 40, 23);
    set_shape(0, 3, 48'h001_001_004_010, 48'h001_001_008_020);
    fill_region(256);
    quiet = 1;
    random_ops(80, 256, 63);
  endtask

  // take results, stalling at random
  initial begin
    tse_result_t exp_r;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        if (expected_results.size() == 0) begin
          $error("result with nothing expected");
          errors++;
        end else begin
          exp_r = expected_results.pop_front();
          if (read_data_o !== exp_r.rdata) begin
            $error("read_data expected %h actual %h", exp_r.rdata, read_data_o);
            errors++;
          end
          if (index_out_of_range_o !== exp_r.oor) begin
            $error("index_out_of_range expected %b actual %b", exp_r.oor,
                   index_out_of_range_o);
            errors++;
          end
        end
      end
      if (!quiet && $urandom_range(0, 7) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  // watchdog on accepted requests, results and register writes
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o) || !rst_ni)
      idle_cycles <= 0;
    else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  initial begin
    m_reduce = 0; m_axis = 3; m_iext = 48'h001_001_001_001; m_oext = 48'h001_001_001_001;
    for (int a = 0; a < 4096; a++) begin
      model_store[a] = '0; written[a] = 0;
    end
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random();
    drain();
    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end
endmodule

[sim.f]
+incdir+rtl/core
rtl/core/tse_pkg.sv
rtl/core/tse_front.sv
rtl/core/tse_back.sv
rtl/core/tensor_scatter_elements_top.sv
rtl/core/tse_checker.sv
bench/tb.sv
